// File: rtl/core/twn_pkg.sv
// ----------------------------------------------------------------------------
// twn_pkg
// Shared types and byte codes for the text whitespace normalizer.
// ----------------------------------------------------------------------------
package twn_pkg;

  localparam int unsigned MaxOut = 4;

  localparam logic [7:0] BYTE_EF    = 8'hEF;
  localparam logic [7:0] BYTE_BB    = 8'hBB;
  localparam logic [7:0] BYTE_BF    = 8'hBF;
  localparam logic [7:0] BYTE_E2    = 8'hE2;
  localparam logic [7:0] BYTE_80    = 8'h80;
  localparam logic [7:0] BYTE_LSQ   = 8'h98;
  localparam logic [7:0] BYTE_RSQ   = 8'h99;
  localparam logic [7:0] BYTE_LDQ   = 8'h9C;
  localparam logic [7:0] BYTE_RDQ   = 8'h9D;
  localparam logic [7:0] BYTE_EN    = 8'h93;
  localparam logic [7:0] BYTE_EM    = 8'h94;
  localparam logic [7:0] BYTE_ELL   = 8'hA6;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  typedef enum logic [2:0] {
    HELD_NONE,
    HELD_EF,
    HELD_EF_BB,
    HELD_E2,
    HELD_E2_80
  } held_t;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SPACE,
    GAP_NEWLINE
  } gap_t;

  typedef struct packed {
    held_t held;
    logic  at_start;
    logic  seen;
    gap_t  gap;
  } state_t;

  localparam state_t STATE_RESET = '{
    held: HELD_NONE, at_start: 1'b1, seen: 1'b0, gap: GAP_NONE
  };

  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [2:0]             cnt;
    logic                   last;
    logic                   bare;
  } list_t;

  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [2:0]             cnt;
    logic                   seen;
    gap_t                   gap;
  } work_t;

endpackage

// File: rtl/core/twn_step.sv
// ----------------------------------------------------------------------------
// twn_step
// Maps one text byte and the current state to up to four output bytes.
// ----------------------------------------------------------------------------
module twn_step (
  input  twn_pkg::state_t state,
  input  logic [7:0]      in_byte,
  input  logic            last,
  output twn_pkg::state_t state_next,
  output twn_pkg::list_t  list
);

  function automatic twn_pkg::work_t emit(twn_pkg::work_t w, logic [7:0] b);
    twn_pkg::work_t r;
    r = w;
    if (r.cnt != 3'd4) begin
      r.data[r.cnt[1:0]] = b;
      r.cnt = r.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic twn_pkg::work_t put_char(twn_pkg::work_t w, logic [7:0] c);
    twn_pkg::work_t r;
    r = w;
    case (c) inside
      twn_pkg::CH_LF, twn_pkg::CH_CR: begin
        r.gap = twn_pkg::GAP_NEWLINE;
      end
      twn_pkg::CH_TAB, twn_pkg::CH_VT, twn_pkg::CH_FF, twn_pkg::CH_SPACE: begin
        if (r.gap == twn_pkg::GAP_NONE) r.gap = twn_pkg::GAP_SPACE;
      end
      default: begin
        if (r.seen && r.gap != twn_pkg::GAP_NONE) begin
          r = emit(r, (r.gap == twn_pkg::GAP_NEWLINE) ? twn_pkg::CH_LF
                                                      : twn_pkg::CH_SPACE);
        end
        r = emit(r, c);
        r.gap = twn_pkg::GAP_NONE;
        r.seen = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic twn_pkg::work_t flush(twn_pkg::work_t w, twn_pkg::held_t h);
    twn_pkg::work_t r;
    r = w;
    case (h)
      twn_pkg::HELD_EF:    r = put_char(r, twn_pkg::BYTE_EF);
      twn_pkg::HELD_EF_BB: r = put_char(put_char(r, twn_pkg::BYTE_EF), twn_pkg::BYTE_BB);
      twn_pkg::HELD_E2:    r = put_char(r, twn_pkg::BYTE_E2);
      twn_pkg::HELD_E2_80: r = put_char(put_char(r, twn_pkg::BYTE_E2), twn_pkg::BYTE_80);
      default:             r = w;
    endcase
    return r;
  endfunction

  twn_pkg::work_t w;
  twn_pkg::held_t h;
  logic           at;
  logic           done;

  always_comb begin
    w      = '{data: '0, cnt: 3'd0, seen: state.seen, gap: state.gap};
    h      = state.held;
    at     = state.at_start;
    done   = 1'b0;

    case (state.held)
      twn_pkg::HELD_EF: begin
        if (in_byte == twn_pkg::BYTE_BB) begin
          h = twn_pkg::HELD_EF_BB;
          done = 1'b1;
        end else begin
          w = flush(w, h);
          h = twn_pkg::HELD_NONE;
        end
      end
      twn_pkg::HELD_EF_BB: begin
        if (in_byte == twn_pkg::BYTE_BF) begin
          h = twn_pkg::HELD_NONE;
          done = 1'b1;
        end else begin
          w = flush(w, h);
          h = twn_pkg::HELD_NONE;
        end
      end
      twn_pkg::HELD_E2: begin
        if (in_byte == twn_pkg::BYTE_80) begin
          h = twn_pkg::HELD_E2_80;
          done = 1'b1;
        end else begin
          w = flush(w, h);
          h = twn_pkg::HELD_NONE;
        end
      end
      twn_pkg::HELD_E2_80: begin
        done = 1'b1;
        h = twn_pkg::HELD_NONE;
        case (in_byte) inside
          twn_pkg::BYTE_LSQ, twn_pkg::BYTE_RSQ: w = put_char(w, twn_pkg::CH_SQUOTE);
          twn_pkg::BYTE_LDQ, twn_pkg::BYTE_RDQ: w = put_char(w, twn_pkg::CH_DQUOTE);
          twn_pkg::BYTE_EN: w = put_char(w, twn_pkg::CH_DASH);
          twn_pkg::BYTE_EM: begin
            w = put_char(w, twn_pkg::CH_SPACE);
            w = put_char(w, twn_pkg::CH_DASH);
            w = put_char(w, twn_pkg::CH_SPACE);
          end
          twn_pkg::BYTE_ELL: begin
            w = put_char(w, twn_pkg::CH_DOT);
            w = put_char(w, twn_pkg::CH_DOT);
            w = put_char(w, twn_pkg::CH_DOT);
          end
          default: begin
            w = flush(w, twn_pkg::HELD_E2_80);
            done = 1'b0;
          end
        endcase
      end
      default: h = twn_pkg::HELD_NONE;
    endcase

    if (!done) begin
      if (at && in_byte == twn_pkg::BYTE_EF) begin
        at = 1'b0;
        h = twn_pkg::HELD_EF;
      end else begin
        at = 1'b0;
        if (in_byte == twn_pkg::BYTE_E2) h = twn_pkg::HELD_E2;
        else w = put_char(w, in_byte);
      end
    end

    list.bare = 1'b0;
    list.last = last;
    if (last) begin
      w = flush(w, h);
      if (w.cnt == 3'd0) begin
        list.bare = 1'b1;
        w.cnt = 3'd1;
      end
      state_next = twn_pkg::STATE_RESET;
    end else begin
      state_next = '{held: h, at_start: at, seen: w.seen, gap: w.gap};
    end
    list.data = w.data;
    list.cnt  = w.cnt;
  end

endmodule

// File: rtl/core/twn_out.sv
// ----------------------------------------------------------------------------
// twn_out
// Result buffer: holds the bytes of one item and sends them one beat a cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module twn_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  twn_pkg::list_t list,
  output logic           can_load,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,   // out_byte
  output logic           m_axis_tuser,   // has_byte
  output logic           m_axis_tlast    // end_of_text
);

  logic [twn_pkg::MaxOut-1:0][7:0] data;
  logic [2:0]                      left;
  logic [1:0]                      pos;
  logic                            last;
  logic                            bare;
  logic                            take;

  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (left != 3'd0);
  assign can_load      = (left == 3'd0) || (left == 3'd1 && m_axis_tready);
  assign m_axis_tdata  = bare ? 8'h00 : data[pos];
  assign m_axis_tuser  = !bare;
  assign m_axis_tlast  = last && (left == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
      pos  <= 2'd0;
    end else if (load) begin
      left <= list.cnt;
      pos  <= 2'd0;
    end else if (take) begin
      left <= left - 3'd1;
      pos  <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= list.data;
      last <= list.last;
      bare <= list.bare;
    end
  end

endmodule

// File: rtl/core/text_whitespace_normalizer_top.sv
// ----------------------------------------------------------------------------
// text_whitespace_normalizer_top
// Byte stream text cleanup: byte order mark removal, quote, dash and ellipsis mapping, whitespace collapsing.
//
//   group   dir  tdata       tuser     tlast
//   s_axis  in   in_byte     -         last
//   m_axis  out  out_byte    has_byte  end_of_text
//
// one input beat per cycle while m_axis_tready is high and each byte yields at most one output beat;
// a byte that yields several beats holds the input until the result buffer sends its last beat
// each input byte passes the input stage register and then the result buffer before its first output beat
// rst is synchronous and clears the input stage, buffer and text state
// m_axis_tready low stalls the buffer and, once it holds beats and the input stage holds a byte, s_axis
// ----------------------------------------------------------------------------
module text_whitespace_normalizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tuser,   // has_byte
  output logic       m_axis_tlast    // end_of_text
);

  logic            q_valid;
  logic [7:0]      q_byte;
  logic            q_last;
  twn_pkg::state_t state;
  twn_pkg::state_t state_next;
  twn_pkg::list_t  list;
  logic            can_load;
  logic            consume;
  logic            load;

  assign load          = q_valid && can_load;
  assign consume       = load;
  assign s_axis_tready = !q_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      q_valid <= 1'b1;
    end else if (consume) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      q_byte <= s_axis_tdata;
      q_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twn_pkg::STATE_RESET;
    end else if (consume) begin
      state <= state_next;
    end
  end

  twn_step u_step (
    .state      (state),
    .in_byte    (q_byte),
    .last       (q_last),
    .state_next (state_next),
    .list       (list)
  );

  twn_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load && list.cnt != 3'd0),
    .list          (list),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_held_after_start: assert property (@(posedge clk) disable iff (rst)
    state.held != twn_pkg::HELD_NONE |-> !state.at_start)
    else $error("prefix held at start of text");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    consume && q_last |=> state.at_start && !state.seen &&
                          state.gap == twn_pkg::GAP_NONE &&
                          state.held == twn_pkg::HELD_NONE)
    else $error("state not cleared after end of text");

  a_last_has_beat: assert property (@(posedge clk) disable iff (rst)
    consume && q_last |-> list.cnt != 3'd0)
    else $error("end of text without a beat");

  a_gap_needs_content: assert property (@(posedge clk) disable iff (rst)
    consume && list.cnt > 3'd1 && !q_last |-> state_next.seen)
    else $error("several beats without content");

endmodule
